// ===== hdl/sclp_pkg.sv =====
// sclp_pkg: shared types, character codes and helper functions
// for the serial command line parser; used by every module in hdl/ but sclp_ram
// no dependencies

package sclp_pkg;

  // line buffer size and the matching index width
  localparam int LINE_LEN    = 64;
  localparam int PTR_W       = $clog2(LINE_LEN);
  // depth of the request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

  // result kinds and error codes
  typedef enum logic [1:0] {
    KIND_LEGACY = 2'd0,
    KIND_RATE   = 2'd1,
    KIND_GAIN   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_USAGE       = 2'd0,
    ERR_OVERFLOW    = 2'd1,
    ERR_UNSUPPORTED = 2'd2,
    ERR_TOO_LONG    = 2'd3
  } err_t;

  // classified requests passed from front to back
  typedef enum logic [2:0] {
    OP_LEGACY = 3'd0,
    OP_OPEN   = 3'd1,
    OP_CHAR   = 3'd2,
    OP_BKSP   = 3'd3,
    OP_END    = 3'd4
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    B_IDLE  = 3'd0,
    B_LEAD  = 3'd1,
    B_KW    = 3'd2,
    B_KWB   = 3'd3,
    B_GAP   = 3'd4,
    B_DIGS  = 3'd5,
    B_TRAIL = 3'd6,
    B_EMIT  = 3'd7
  } back_state_t;

  // character codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_FIRST = 8'h20;
  localparam logic [7:0] CH_SUB   = 8'h01;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // keywords, first character in the top byte
  localparam logic [31:0] RATE_WORD = 32'h72617465;
  localparam logic [31:0] GAIN_WORD = 32'h6761696E;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // control bytes other than tab and non-printable bytes are stored as a substitute code
  function automatic logic [7:0] map_char(input logic [7:0] c);
    if (((c < CH_FIRST) && (c != CH_TAB)) || (c > CH_TILDE)) begin
      return CH_SUB;
    end
    return c;
  endfunction

  // keyword character at a position, position 0 first
  function automatic logic [7:0] kw_char(input logic [31:0] word, input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = word[31:24];
      2'd1:    c = word[23:16];
      2'd2:    c = word[15:8];
      default: c = word[7:0];
    endcase
    return c;
  endfunction

  // supported data rates
  function automatic logic rate_ok(input logic [31:0] v);
    return v inside {32'd250, 32'd500, 32'd1000, 32'd2000, 32'd4000, 32'd8000, 32'd16000};
  endfunction

  // supported gains
  function automatic logic gain_ok(input logic [31:0] v);
    return v inside {32'd1, 32'd2, 32'd4, 32'd6, 32'd8, 32'd12, 32'd24};
  endfunction

endpackage

// ===== hdl/sclp_ram.sv =====
// sclp_ram: generic single write port ram with registered read
// no dependencies

module sclp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/sclp_front.sv =====
// sclp_front: accepts received bytes, tracks whether a line is open and
// classifies each byte into a request for the back end; uses sclp_pkg

module sclp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               q_full,
  output logic               push,
  output sclp_pkg::cmd_t     push_cmd
);

  logic active_r;
  logic active_nxt;
  logic accept;
  logic has_cmd;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // byte classification
  always_comb begin
    active_nxt    = active_r;
    has_cmd       = 1'b0;
    push_cmd.op   = sclp_pkg::OP_LEGACY;
    push_cmd.data = in_rx_byte;
    if (!active_r) begin
      if (in_rx_byte == sclp_pkg::CH_COLON) begin
        has_cmd     = 1'b1;
        push_cmd.op = sclp_pkg::OP_OPEN;
        active_nxt  = 1'b1;
      end else if (!(in_rx_byte inside {sclp_pkg::CH_CR, sclp_pkg::CH_LF, sclp_pkg::CH_SPACE,
                                         sclp_pkg::CH_TAB, sclp_pkg::CH_BS,
                                         sclp_pkg::CH_DEL})) begin
        has_cmd     = 1'b1;
        push_cmd.op = sclp_pkg::OP_LEGACY;
      end
    end else begin
      has_cmd = 1'b1;
      if ((in_rx_byte == sclp_pkg::CH_CR) || (in_rx_byte == sclp_pkg::CH_LF)) begin
        push_cmd.op = sclp_pkg::OP_END;
        active_nxt  = 1'b0;
      end else if ((in_rx_byte == sclp_pkg::CH_BS) || (in_rx_byte == sclp_pkg::CH_DEL)) begin
        push_cmd.op = sclp_pkg::OP_BKSP;
      end else begin
        push_cmd.op   = sclp_pkg::OP_CHAR;
        push_cmd.data = sclp_pkg::map_char(in_rx_byte);
      end
    end
  end

  assign push = accept && has_cmd;

  // line open flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (accept) begin
      active_r <= active_nxt;
    end
  end

endmodule

// ===== hdl/sclp_queue.sv =====
// sclp_queue: short request queue between front and back end
// uses sclp_pkg for the request type and depth

module sclp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sclp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output sclp_pkg::cmd_t head_cmd
);

  localparam int CNT_W = sclp_pkg::Q_PTR_W + 1;

  sclp_pkg::cmd_t                 entries_r [sclp_pkg::QUEUE_DEPTH];
  logic [sclp_pkg::Q_PTR_W-1:0]   wr_ptr_r;
  logic [sclp_pkg::Q_PTR_W-1:0]   wr_ptr_nxt;
  logic [sclp_pkg::Q_PTR_W-1:0]   rd_ptr_r;
  logic [sclp_pkg::Q_PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]               count_r;
  logic [CNT_W-1:0]               count_nxt;
  logic                           do_pop;

  assign full       = (count_r == CNT_W'(sclp_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entries_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == sclp_pkg::Q_PTR_W'(sclp_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == sclp_pkg::Q_PTR_W'(sclp_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/sclp_back.sv =====
// sclp_back: carries out queued requests, keeps the line buffer and walks
// it at line end to parse the command; uses sclp_pkg and sclp_ram

module sclp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  sclp_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_kind,
  output logic [31:0]    out_value,
  output logic [1:0]     out_error_code
);

  localparam int PW = sclp_pkg::PTR_W;

  sclp_pkg::back_state_t state_r;
  sclp_pkg::back_state_t state_nxt;

  logic [PW-1:0] fill_r;
  logic [PW-1:0] fill_nxt;
  logic          ovf_r;
  logic          ovf_nxt;
  logic [PW-1:0] pos_r;
  logic [PW-1:0] pos_nxt;
  logic [1:0]    kidx_r;
  logic [1:0]    kidx_nxt;
  logic          rate_hit_r;
  logic          rate_hit_nxt;
  logic          gain_hit_r;
  logic          gain_hit_nxt;
  logic          is_rate_r;
  logic          is_rate_nxt;
  logic [31:0]   val_r;
  logic [31:0]   val_nxt;
  logic [1:0]    res_kind_r;
  logic [1:0]    res_kind_nxt;
  logic [31:0]   res_value_r;
  logic [31:0]   res_value_nxt;
  logic [1:0]    res_err_r;
  logic [1:0]    res_err_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic [1:0]    out_kind_r;
  logic [1:0]    out_kind_nxt;
  logic [31:0]   out_value_r;
  logic [31:0]   out_value_nxt;
  logic [1:0]    out_err_r;
  logic [1:0]    out_err_nxt;

  logic          ram_we;
  logic [7:0]    ram_rdata;

  logic [7:0]    c;
  logic          at_end;
  logic          blank;
  logic          digit;
  logic          short_line;
  logic          slot_free;
  logic          line_full;
  logic [7:0]    dig_full;
  logic [3:0]    dig;
  logic [35:0]   acc;
  logic          acc_ovf;
  logic          supported;

  // line buffer, read address follows the next scan position
  sclp_ram #(
    .WIDTH (8),
    .DEPTH (sclp_pkg::LINE_LEN)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (fill_r),
    .wr_data (q_cmd.data),
    .rd_addr (pos_nxt),
    .rd_data (ram_rdata)
  );

  // scan helpers
  assign c          = ram_rdata;
  assign at_end     = (pos_r == fill_r);
  assign blank      = sclp_pkg::is_blank(c);
  assign digit      = sclp_pkg::is_digit(c);
  assign short_line = ((fill_r - pos_r) < PW'(5));
  assign slot_free  = !out_valid_r || !out_stall;
  assign line_full  = (fill_r == PW'(sclp_pkg::LINE_LEN - 1));
  assign q_pop      = (state_r == sclp_pkg::B_IDLE) && q_valid;
  assign ram_we     = q_pop && (q_cmd.op == sclp_pkg::OP_CHAR) && !ovf_r && !line_full;

  // decimal accumulate: v * 10 + d, wide enough to see overflow
  assign dig_full = c - sclp_pkg::CH_ZERO;
  assign dig      = dig_full[3:0];
  assign acc      = ({4'b0, val_r} << 3) + ({4'b0, val_r} << 1) + {32'b0, dig};
  assign acc_ovf  = (acc[35:32] != 4'b0);
  assign supported = is_rate_r ? sclp_pkg::rate_ok(val_r) : sclp_pkg::gain_ok(val_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sclp_pkg::B_IDLE: begin
        if (q_valid) begin
          if (q_cmd.op == sclp_pkg::OP_LEGACY) begin
            state_nxt = sclp_pkg::B_EMIT;
          end else if (q_cmd.op == sclp_pkg::OP_END) begin
            state_nxt = ovf_r ? sclp_pkg::B_EMIT : sclp_pkg::B_LEAD;
          end
        end
      end
      sclp_pkg::B_LEAD: begin
        if (at_end) begin
          state_nxt = sclp_pkg::B_IDLE;
        end else if (!blank) begin
          state_nxt = short_line ? sclp_pkg::B_EMIT : sclp_pkg::B_KW;
        end
      end
      sclp_pkg::B_KW: begin
        if (kidx_r == 2'd3) begin
          state_nxt = sclp_pkg::B_KWB;
        end
      end
      sclp_pkg::B_KWB: begin
        state_nxt = (blank && (rate_hit_r || gain_hit_r)) ? sclp_pkg::B_GAP : sclp_pkg::B_EMIT;
      end
      sclp_pkg::B_GAP: begin
        if (at_end) begin
          state_nxt = sclp_pkg::B_EMIT;
        end else if (digit) begin
          state_nxt = acc_ovf ? sclp_pkg::B_EMIT : sclp_pkg::B_DIGS;
        end else if (!blank) begin
          state_nxt = sclp_pkg::B_EMIT;
        end
      end
      sclp_pkg::B_DIGS: begin
        if (at_end) begin
          state_nxt = sclp_pkg::B_EMIT;
        end else if (digit) begin
          state_nxt = acc_ovf ? sclp_pkg::B_EMIT : sclp_pkg::B_DIGS;
        end else if (blank) begin
          state_nxt = sclp_pkg::B_TRAIL;
        end else begin
          state_nxt = sclp_pkg::B_EMIT;
        end
      end
      sclp_pkg::B_TRAIL: begin
        if (at_end || !blank) begin
          state_nxt = sclp_pkg::B_EMIT;
        end
      end
      sclp_pkg::B_EMIT: begin
        if (slot_free) begin
          state_nxt = sclp_pkg::B_IDLE;
        end
      end
      default: state_nxt = sclp_pkg::B_IDLE;
    endcase
  end

  // datapath and result outputs
  always_comb begin
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    pos_nxt       = pos_r;
    kidx_nxt      = kidx_r;
    rate_hit_nxt  = rate_hit_r;
    gain_hit_nxt  = gain_hit_r;
    is_rate_nxt   = is_rate_r;
    val_nxt       = val_r;
    res_kind_nxt  = res_kind_r;
    res_value_nxt = res_value_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    case (state_r)
      sclp_pkg::B_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            sclp_pkg::OP_LEGACY: begin
              res_kind_nxt  = sclp_pkg::KIND_LEGACY;
              res_value_nxt = {24'b0, q_cmd.data};
              res_err_nxt   = sclp_pkg::ERR_USAGE;
            end
            sclp_pkg::OP_OPEN: begin
              fill_nxt = '0;
              ovf_nxt  = 1'b0;
            end
            sclp_pkg::OP_CHAR: begin
              if (!ovf_r) begin
                if (line_full) begin
                  ovf_nxt = 1'b1;
                end else begin
                  fill_nxt = fill_r + 1'b1;
                end
              end
            end
            sclp_pkg::OP_BKSP: begin
              if (!ovf_r && (fill_r != '0)) begin
                fill_nxt = fill_r - 1'b1;
              end
            end
            sclp_pkg::OP_END: begin
              pos_nxt       = '0;
              res_kind_nxt  = sclp_pkg::KIND_ERROR;
              res_value_nxt = '0;
              res_err_nxt   = sclp_pkg::ERR_TOO_LONG;
            end
            default: ;
          endcase
        end
      end
      // skip leading blanks, then take the first keyword character
      sclp_pkg::B_LEAD: begin
        res_err_nxt = sclp_pkg::ERR_USAGE;
        if (!at_end) begin
          pos_nxt      = pos_r + 1'b1;
          rate_hit_nxt = (c == sclp_pkg::kw_char(sclp_pkg::RATE_WORD, 2'd0));
          gain_hit_nxt = (c == sclp_pkg::kw_char(sclp_pkg::GAIN_WORD, 2'd0));
          kidx_nxt     = 2'd1;
        end
      end
      // remaining keyword characters
      sclp_pkg::B_KW: begin
        pos_nxt      = pos_r + 1'b1;
        kidx_nxt     = kidx_r + 1'b1;
        rate_hit_nxt = rate_hit_r && (c == sclp_pkg::kw_char(sclp_pkg::RATE_WORD, kidx_r));
        gain_hit_nxt = gain_hit_r && (c == sclp_pkg::kw_char(sclp_pkg::GAIN_WORD, kidx_r));
      end
      // blank after the keyword
      sclp_pkg::B_KWB: begin
        pos_nxt     = pos_r + 1'b1;
        is_rate_nxt = rate_hit_r;
        val_nxt     = '0;
      end
      // blanks before the number, then its digits, and the result at line end
      sclp_pkg::B_GAP, sclp_pkg::B_DIGS: begin
        if (at_end) begin
          if (state_r == sclp_pkg::B_DIGS) begin
            res_kind_nxt  = supported ? (is_rate_r ? sclp_pkg::KIND_RATE : sclp_pkg::KIND_GAIN)
                                      : sclp_pkg::KIND_ERROR;
            res_value_nxt = supported ? val_r : '0;
            res_err_nxt   = supported ? sclp_pkg::ERR_USAGE : sclp_pkg::ERR_UNSUPPORTED;
          end
        end else begin
          pos_nxt = pos_r + 1'b1;
          if (digit) begin
            val_nxt = acc[31:0];
            if (acc_ovf) begin
              res_err_nxt = sclp_pkg::ERR_OVERFLOW;
            end
          end
        end
      end
      // trailing blanks
      sclp_pkg::B_TRAIL: begin
        if (at_end) begin
          res_kind_nxt  = supported ? (is_rate_r ? sclp_pkg::KIND_RATE : sclp_pkg::KIND_GAIN)
                                    : sclp_pkg::KIND_ERROR;
          res_value_nxt = supported ? val_r : '0;
          res_err_nxt   = supported ? sclp_pkg::ERR_USAGE : sclp_pkg::ERR_UNSUPPORTED;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      // hand the pending result to the output register
      sclp_pkg::B_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_value_nxt = res_value_r;
          out_err_nxt   = res_err_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sclp_pkg::B_IDLE;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kidx_r      <= kidx_nxt;
    rate_hit_r  <= rate_hit_nxt;
    gain_hit_r  <= gain_hit_nxt;
    is_rate_r   <= is_rate_nxt;
    val_r       <= val_nxt;
    res_kind_r  <= res_kind_nxt;
    res_value_r <= res_value_nxt;
    res_err_r   <= res_err_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_value      = out_value_r;
  assign out_error_code = out_err_r;

endmodule

// ===== hdl/serial_command_line_parser_top.sv =====
// serial_command_line_parser_top: top level of the serial command line parser
// depends on sclp_pkg, sclp_front, sclp_queue, sclp_back (and sclp_ram)
//
// Usage:
//   in_valid / in_stall / in_rx_byte carry one received byte per request.
//   out_valid / out_stall carry zero or one result per byte: out_kind,
//   out_value and out_error_code (error code is 0 unless kind is error).
//   The front classifies each byte in the cycle it is taken and pushes a
//   request into a two-entry queue; the back carries requests out one at a
//   time. Buffered characters, line opens and backspaces are handled in the
//   idle state, a legacy byte also passes the emit state. A line end walks
//   the stored line one byte per cycle from the line ram's registered read
//   port before the result reaches the output register. A legacy result
//   passes the queue and the back end's result and output registers on its
//   way to out_valid. in_stall rises only while the queue is full; while
//   out_stall holds a result, the back waits on its next result and the
//   queue fills behind it. Reset (rst_n low, synchronous) closes any open
//   line, empties the queue and the output register; the line ram needs no
//   clearing since only entries written in the current line are read.

module serial_command_line_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [31:0] out_value,
  output logic [1:0]  out_error_code
);

  logic           q_full;
  logic           push;
  sclp_pkg::cmd_t push_cmd;
  logic           q_pop;
  logic           q_valid;
  sclp_pkg::cmd_t q_cmd;

  // byte classification
  sclp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // request queue
  sclp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  // line buffer, parser and output register
  sclp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_value      (out_value),
    .out_error_code (out_error_code)
  );

endmodule

// ===== verif/serial_command_line_parser_top_tb.sv =====
// serial_command_line_parser_top_tb: self-checking bench for the serial command line parser
// feeds legacy bytes and ':' command lines, predicts each result and compares it field by field
// depends on sclp_pkg and serial_command_line_parser_top from hdl/
`timescale 1ns / 1ps

module serial_command_line_parser_top_tb;

  localparam int ITEMS       = 1650;
  localparam int HOLD_CYCLES = 300;
  // error code reads zero outside errors
  localparam sclp_pkg::err_t NO_ERR = sclp_pkg::ERR_USAGE;

  typedef struct packed {
    sclp_pkg::kind_t kind;
    logic [31:0]     value;
    sclp_pkg::err_t  err;
  } command_t;

  // line predictor plus the queue of commands still to come out
  class command_scoreboard;
    logic [7:0]  line_buf [sclp_pkg::LINE_LEN];
    bit          line_open;
    int unsigned fill;
    bit          line_dropped;
    command_t    expected_cmds[$];
    int          fails;
    int          counted_bytes;

    function bit blank_char(logic [7:0] c);
      return c == sclp_pkg::CH_SPACE || c == sclp_pkg::CH_TAB;
    endfunction

    function bit digit_char(logic [7:0] c);
      return c >= sclp_pkg::CH_ZERO && c <= sclp_pkg::CH_NINE;
    endfunction

    function bit supported(sclp_pkg::kind_t k, logic [31:0] v);
      int unsigned rates [7];
      int unsigned gains [7];
      rates = '{250, 500, 1000, 2000, 4000, 8000, 16000};
      gains = '{1, 2, 4, 6, 8, 12, 24};
      for (int j = 0; j < 7; j++) begin
        if ((k == sclp_pkg::KIND_RATE) ? (v == rates[j]) : (v == gains[j])) begin
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void add_cmd(sclp_pkg::kind_t k, logic [31:0] v, sclp_pkg::err_t e);
      command_t c;
      c.kind  = k;
      c.value = v;
      c.err   = e;
      expected_cmds.push_back(c);
    endfunction

    // parse the closed line as a rate or gain command
    function void decode_line();
      int unsigned     pos;
      int unsigned     stop;
      longint unsigned num;
      sclp_pkg::kind_t k;
      stop = fill;
      pos  = 0;
      num  = 0;
      while (pos < stop && blank_char(line_buf[pos])) pos++;
      if (pos == stop) return;
      if (stop - pos < 5 || !blank_char(line_buf[pos + 4])) begin
        add_cmd(sclp_pkg::KIND_ERROR, 0, sclp_pkg::ERR_USAGE);
        return;
      end
      if ({line_buf[pos], line_buf[pos + 1], line_buf[pos + 2],
           line_buf[pos + 3]} == sclp_pkg::RATE_WORD) begin
        k = sclp_pkg::KIND_RATE;
      end else if ({line_buf[pos], line_buf[pos + 1], line_buf[pos + 2],
                    line_buf[pos + 3]} == sclp_pkg::GAIN_WORD) begin
        k = sclp_pkg::KIND_GAIN;
      end else begin
        add_cmd(sclp_pkg::KIND_ERROR, 0, sclp_pkg::ERR_USAGE);
        return;
      end
      pos += 4;
      while (pos < stop && blank_char(line_buf[pos])) pos++;
      if (pos == stop || !digit_char(line_buf[pos])) begin
        add_cmd(sclp_pkg::KIND_ERROR, 0, sclp_pkg::ERR_USAGE);
        return;
      end
      // overflow is caught digit by digit, ahead of any trailing junk
      while (pos < stop && digit_char(line_buf[pos])) begin
        num = num * 10 + (line_buf[pos] - sclp_pkg::CH_ZERO);
        if (num > 64'hFFFF_FFFF) begin
          add_cmd(sclp_pkg::KIND_ERROR, 0, sclp_pkg::ERR_OVERFLOW);
          return;
        end
        pos++;
      end
      while (pos < stop && blank_char(line_buf[pos])) pos++;
      if (pos != stop) begin
        add_cmd(sclp_pkg::KIND_ERROR, 0, sclp_pkg::ERR_USAGE);
        return;
      end
      if (!supported(k, num[31:0])) begin
        add_cmd(sclp_pkg::KIND_ERROR, 0, sclp_pkg::ERR_UNSUPPORTED);
        return;
      end
      add_cmd(k, num[31:0], NO_ERR);
    endfunction

    // one accepted request
    function void take_byte(logic [7:0] c);
      counted_bytes++;
      if (!line_open) begin
        if (c == sclp_pkg::CH_COLON) begin
          line_open    = 1'b1;
          fill         = 0;
          line_dropped = 1'b0;
          return;
        end
        if (c == sclp_pkg::CH_CR || c == sclp_pkg::CH_LF || c == sclp_pkg::CH_SPACE ||
            c == sclp_pkg::CH_TAB || c == sclp_pkg::CH_BS || c == sclp_pkg::CH_DEL) return;
        add_cmd(sclp_pkg::KIND_LEGACY, {24'd0, c}, NO_ERR);
        return;
      end
      if (c == sclp_pkg::CH_CR || c == sclp_pkg::CH_LF) begin
        line_open = 1'b0;
        if (line_dropped) begin
          add_cmd(sclp_pkg::KIND_ERROR, 0, sclp_pkg::ERR_TOO_LONG);
        end else begin
          decode_line();
        end
        return;
      end
      if (line_dropped) return;
      if (c == sclp_pkg::CH_BS || c == sclp_pkg::CH_DEL) begin
        if (fill > 0) fill--;
        return;
      end
      if (fill >= sclp_pkg::LINE_LEN - 1) begin
        line_dropped = 1'b1;
        return;
      end
      line_buf[fill] = ((c < sclp_pkg::CH_FIRST && c != sclp_pkg::CH_TAB) ||
                        c > sclp_pkg::CH_TILDE) ? sclp_pkg::CH_SUB : c;
      fill++;
    endfunction

    function void note_fail(string msg);
      fails++;
      if (fails <= 10) $display("mismatch %0d: %s", fails, msg);
    endfunction

    // one accepted result against the oldest expected command
    function void check_command(logic [1:0] k, logic [31:0] v, logic [1:0] e);
      command_t x;
      if (expected_cmds.size() == 0) begin
        note_fail($sformatf("unexpected result kind %0d value %0d code %0d", k, v, e));
        return;
      end
      x = expected_cmds.pop_front();
      if (k !== x.kind) note_fail($sformatf("kind exp %0d got %0d", x.kind, k));
      if (v !== x.value) note_fail($sformatf("value exp %0d got %0d", x.value, v));
      if (e !== x.err) note_fail($sformatf("error code exp %0d got %0d", x.err, e));
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction

    function void close_out();
      if (expected_cmds.size() != 0) begin
        note_fail($sformatf("%0d results never arrived", expected_cmds.size()));
      end
    endfunction
  endclass

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte     = 8'd0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [1:0]  out_kind;
  logic [31:0] out_value;
  logic [1:0]  out_error_code;

  command_scoreboard sb = new();
  bit                idle_en = 1'b1;
  int                hold_gen = 0;
  logic [7:0]        burst[$];

  serial_command_line_parser_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_value      (out_value),
    .out_error_code (out_error_code)
  );

  always #4 clk = ~clk;

  // run limit
  initial begin
    #4_000_000;
    $display("serial_command_line_parser_top verification failed");
    $finish;
  end

  // offer one byte, with random gaps while idle_en is set, until it is taken
  task automatic send_byte(input logic [7:0] b);
    if (idle_en) begin
      while ($urandom_range(99) < 37) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.take_byte(b);
  endtask

  task automatic send_burst();
    foreach (burst[k]) send_byte(burst[k]);
    burst.delete();
  endtask

  task automatic add_text(input string s);
    for (int k = 0; k < s.len(); k++) burst.push_back(s[k]);
  endtask

  task automatic add_blanks(input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) begin
      burst.push_back($urandom_range(1) ? sclp_pkg::CH_SPACE : sclp_pkg::CH_TAB);
    end
  endtask

  task automatic add_erase();
    burst.push_back($urandom_range(1) ? sclp_pkg::CH_BS : sclp_pkg::CH_DEL);
  endtask

  task automatic add_line_end();
    burst.push_back($urandom_range(1) ? sclp_pkg::CH_CR : sclp_pkg::CH_LF);
  endtask

  // control or non-printable byte that is not a tab, a line end or an erase
  function automatic logic [7:0] odd_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while ((c >= sclp_pkg::CH_FIRST && c <= sclp_pkg::CH_TILDE) || c == sclp_pkg::CH_TAB ||
           c == sclp_pkg::CH_CR || c == sclp_pkg::CH_LF || c == sclp_pkg::CH_BS ||
           c == sclp_pkg::CH_DEL);
    return c;
  endfunction

  // number text: mostly supported values, some odd ones and some past 32 bits
  function automatic string pick_number(input bit is_rate);
    int unsigned rates [7];
    int unsigned gains [7];
    int unsigned r;
    rates = '{250, 500, 1000, 2000, 4000, 8000, 16000};
    gains = '{1, 2, 4, 6, 8, 12, 24};
    r = $urandom_range(99);
    if (r < 55) return $sformatf("%0d", is_rate ? rates[$urandom_range(6)] : gains[$urandom_range(6)]);
    if (r < 62) return $sformatf("00%0d", is_rate ? rates[$urandom_range(6)] : gains[$urandom_range(6)]);
    if (r < 78) return $sformatf("%0d", $urandom_range(30000));
    if (r < 85) return $sformatf("%0d", $urandom());
    if (r < 93) return $sformatf("%0d", 64'd4294967296 + $urandom_range(1000000));
    case ($urandom_range(2))
      0:       return "4294967295";
      1:       return "4294967296";
      default: return "99999999999999999999";
    endcase
  endfunction

  task automatic add_command_body();
    bit is_rate;
    is_rate = $urandom_range(1);
    add_blanks(0, 2);
    if (is_rate) add_text("rate");
    else add_text("gain");
    add_blanks(1, 3);
    // an edit just before the number
    if ($urandom_range(4) == 0) begin
      burst.push_back(8'($urandom_range(8'h61, 8'h7A)));
      add_erase();
    end
    add_text(pick_number(is_rate));
    add_blanks(0, 2);
  endtask

  task automatic add_command_line();
    burst.push_back(sclp_pkg::CH_COLON);
    add_command_body();
    add_line_end();
  endtask

  // erases on an empty line, typed junk taken back, then a command
  task automatic add_edited_line();
    int junk;
    burst.push_back(sclp_pkg::CH_COLON);
    repeat ($urandom_range(3, 1)) add_erase();
    junk = $urandom_range(5, 1);
    repeat (junk) burst.push_back(8'($urandom_range(8'h61, 8'h7A)));
    repeat (junk + $urandom_range(1)) add_erase();
    add_command_body();
    add_line_end();
  endtask

  // usage errors of several sorts, and an overflow ahead of trailing junk
  task automatic add_broken_line();
    burst.push_back(sclp_pkg::CH_COLON);
    case ($urandom_range(7))
      0: add_text("rate250");
      1: add_text("gain  ");
      2: add_text($urandom_range(1) ? "rate 250x" : "gain 2 3");
      3: add_text($urandom_range(1) ? "rats 250" : "Gain 2");
      4: add_text("rat");
      5: begin
        add_text("rate 2");
        burst.push_back(odd_byte());
        add_text("50");
      end
      6: add_text($urandom_range(1) ? "rate: 250" : "gain 2:");
      default: add_text("rate 4294967296x");
    endcase
    add_line_end();
  endtask

  task automatic add_random_line();
    logic [7:0] c;
    burst.push_back(sclp_pkg::CH_COLON);
    repeat ($urandom_range(20)) begin
      do c = 8'($urandom_range(255)); while (c == sclp_pkg::CH_CR || c == sclp_pkg::CH_LF);
      burst.push_back(c);
    end
    add_line_end();
  endtask

  // lengths around the buffer limit
  task automatic add_long_line();
    int    span;
    int    gap;
    bit    is_rate;
    string num;
    span = $urandom_range(68, 58);
    burst.push_back(sclp_pkg::CH_COLON);
    if ($urandom_range(1)) begin
      is_rate = $urandom_range(1);
      if (is_rate) num = $urandom_range(1) ? "250" : "16000";
      else num = $urandom_range(1) ? "1" : "24";
      gap = span - 4 - num.len();
      if (is_rate) add_text("rate");
      else add_text("gain");
      add_blanks(gap, gap);
      add_text(num);
    end else begin
      repeat (span + $urandom_range(20)) burst.push_back(8'($urandom_range(126, 33)));
    end
    if ($urandom_range(3) == 0) begin
      add_erase();
      burst.push_back(8'h7A);
    end
    add_line_end();
  endtask

  task automatic add_blank_line();
    burst.push_back(sclp_pkg::CH_COLON);
    add_blanks(0, 4);
    if ($urandom_range(2) == 0) begin
      add_text("ab");
      add_erase();
      add_erase();
    end
    add_line_end();
  endtask

  // result side: take results and stall at random or for a long hold
  initial begin : result_side
    int hold_left;
    int seen_gen;
    hold_left = 0;
    seen_gen  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_command(out_kind, out_value, out_error_code);
      end
      if (hold_gen != seen_gen) begin
        seen_gen  = hold_gen;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (idle_en) begin
        out_stall <= ($urandom_range(99) < 37);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // byte side: directed requests, then random lines and noise
  initial begin : byte_side
    int pick;
    int guard;
    bit pressure_done;
    pressure_done = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // legacy extremes, ignored bytes while idle, an empty line
    burst = '{8'h00, 8'hFF, 8'h41, sclp_pkg::CH_CR, sclp_pkg::CH_LF, sclp_pkg::CH_SPACE,
              sclp_pkg::CH_TAB, sclp_pkg::CH_BS, sclp_pkg::CH_DEL, sclp_pkg::CH_COLON,
              sclp_pkg::CH_CR};
    // erase on an empty line, then a good gain
    burst.push_back(sclp_pkg::CH_COLON);
    burst.push_back(sclp_pkg::CH_BS);
    add_text("gain 1");
    burst.push_back(sclp_pkg::CH_LF);
    // colon kept as a character inside a line
    burst.push_back(sclp_pkg::CH_COLON);
    add_text("x:");
    burst.push_back(sclp_pkg::CH_DEL);
    burst.push_back(sclp_pkg::CH_COLON);
    burst.push_back(sclp_pkg::CH_CR);
    send_burst();

    while (sb.counted_bytes < ITEMS) begin
      idle_en = !(sb.counted_bytes >= 900 && sb.counted_bytes < 1200);
      // long receiver hold while legacy bytes keep coming
      if (!pressure_done && sb.counted_bytes >= 500) begin
        pressure_done = 1'b1;
        burst.push_back(sclp_pkg::CH_LF);
        send_burst();
        hold_gen <= hold_gen + 1;
        repeat (24) burst.push_back(8'($urandom_range(8'h5A, 8'h41)));
        send_burst();
      end
      pick = $urandom_range(99);
      if (pick < 40) add_command_line();
      else if (pick < 50) add_edited_line();
      else if (pick < 65) add_broken_line();
      else if (pick < 75) add_random_line();
      else if (pick < 82) add_long_line();
      else if (pick < 88) add_blank_line();
      else repeat ($urandom_range(6, 1)) burst.push_back(8'($urandom_range(255)));
      send_burst();
    end
    in_valid <= 1'b0;

    // drain, then allow for a full line walk
    guard = 0;
    while (sb.pending() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (150) @(posedge clk);
    sb.close_out();
    if (sb.fails == 0) begin
      $display("serial_command_line_parser_top verification clean");
    end else begin
      $display("serial_command_line_parser_top verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sclp_pkg.sv
hdl/sclp_ram.sv
hdl/sclp_front.sv
hdl/sclp_queue.sv
hdl/sclp_back.sv
hdl/serial_command_line_parser_top.sv
verif/serial_command_line_parser_top_tb.sv
